// ----- hdl/smsort_pkg.sv -----
package smsort_pkg;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_RUN   = 6'b000010,
        S_READ  = 6'b000100,
        S_CMP   = 6'b001000,
        S_EREAD = 6'b010000,
        S_EOUT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic a_ok;
        logic b_ok;
    } t_cmp_ctl;

endpackage

// ----- hdl/smsort_ram.sv -----
module smsort_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [W-1:0]  o_rdata_a,
    output logic [W-1:0]  o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- hdl/smsort_cmp.sv -----
module smsort_cmp #(
    parameter int W = 32
) (
    input  smsort_pkg::t_cmp_ctl i_ctl,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_b,
    output logic                 o_take_a,
    output logic [W-1:0]         o_data
);

    // take the earlier run on ties to keep the sort stable
    assign o_take_a = i_ctl.a_ok && (!i_ctl.b_ok || ($signed(i_a) <= $signed(i_b)));
    assign o_data   = o_take_a ? i_a : i_b;

endmodule

// ----- hdl/stable_merge_sorter_core.sv -----
// Channel | Ports                                    | Handshake
// input   | i_value, i_last                          | taken when start & !busy
// result  | o_value_res, o_last_res, o_overflow      | one cycle, marked by o_strobe
//
// Loading accepts one word per cycle; busy stays low while a list is collected.
// After the last word, each merge pass sets up each run, then takes every element
// through a registered RAM read, then compare and write via the shared compare
// unit; ceil(log2(n)) passes. Emission reads each result word, then emits it.
// Synchronous active-low reset returns to loading with an empty list; the RAMs
// are not cleared. The receiver cannot stall: a result is gone after its cycle.
module stable_merge_sorter_core #(
    parameter int MAX_ITEMS   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_last,
    output logic                          o_strobe,
    output logic signed [VALUE_WIDTH-1:0] o_value_res,
    output logic                          o_last_res,
    output logic                          o_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int EW = CW + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    smsort_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_dropped, n_dropped;
    logic [CW-1:0] r_n, n_n;
    logic [CW:0]   r_w, n_w;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic          r_src, n_src;

    logic [EW-1:0]          sum_mid, sum_hi, w2;
    logic [CW-1:0]          cnt_inc, k_inc;
    logic                   accept;
    logic                   we0, we1, wr_load, wr_merge;
    logic [AW-1:0]          waddr, raddr_a, raddr_b;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [VALUE_WIDTH-1:0] m0_a, m0_b, m1_a, m1_b, rd_a, rd_b;
    logic [VALUE_WIDTH-1:0] cmp_data;
    logic                   take_a;
    smsort_pkg::t_cmp_ctl   cmp_ctl;

    assign accept   = start && !busy;
    assign busy     = (r_state != smsort_pkg::S_LOAD);
    assign cnt_inc  = r_count + 1'b1;
    assign k_inc    = r_k + 1'b1;
    assign sum_mid  = {2'b00, r_lo} + {1'b0, r_w};
    assign sum_hi   = {2'b00, r_lo} + {r_w, 1'b0};
    assign w2       = {r_w, 1'b0};

    assign wr_load  = accept && (r_count < MAX_CNT);
    assign wr_merge = (r_state == smsort_pkg::S_CMP);
    assign we0      = wr_load || (wr_merge && r_src);
    assign we1      = wr_merge && !r_src;
    assign waddr    = wr_load ? r_count[AW-1:0] : r_k[AW-1:0];
    assign wdata    = wr_load ? VALUE_WIDTH'(i_value) : cmp_data;
    assign raddr_a  = (r_state == smsort_pkg::S_EREAD) ? r_k[AW-1:0] : r_i[AW-1:0];
    assign raddr_b  = r_j[AW-1:0];
    assign rd_a     = r_src ? m1_a : m0_a;
    assign rd_b     = r_src ? m1_b : m0_b;

    assign cmp_ctl.a_ok = (r_i < r_mid);
    assign cmp_ctl.b_ok = (r_j < r_hi);

    smsort_ram #(.W(VALUE_WIDTH), .DEPTH(MAX_ITEMS), .AW(AW)) u_mem0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (m0_a),
        .o_rdata_b (m0_b)
    );

    smsort_ram #(.W(VALUE_WIDTH), .DEPTH(MAX_ITEMS), .AW(AW)) u_mem1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (m1_a),
        .o_rdata_b (m1_b)
    );

    smsort_cmp #(.W(VALUE_WIDTH)) u_cmp (
        .i_ctl    (cmp_ctl),
        .i_a      (rd_a),
        .i_b      (rd_b),
        .o_take_a (take_a),
        .o_data   (cmp_data)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_n       = r_n;
        n_w       = r_w;
        n_lo      = r_lo;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_src     = r_src;
        unique case (r_state)
            smsort_pkg::S_LOAD: begin
                if (accept) begin
                    if (r_count < MAX_CNT) begin
                        n_count = cnt_inc;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_last) begin
                        n_n   = (r_count < MAX_CNT) ? cnt_inc : r_count;
                        n_w   = (CW+1)'(1);
                        n_lo  = '0;
                        n_k   = '0;
                        n_src = 1'b0;
                        n_state = (n_n == CW'(1)) ? smsort_pkg::S_EREAD
                                                  : smsort_pkg::S_RUN;
                    end
                end
            end
            smsort_pkg::S_RUN: begin
                n_mid = (sum_mid > {2'b00, r_n}) ? r_n : sum_mid[CW-1:0];
                n_hi  = (sum_hi > {2'b00, r_n}) ? r_n : sum_hi[CW-1:0];
                n_i   = r_lo;
                n_j   = n_mid;
                n_k   = r_lo;
                n_state = smsort_pkg::S_READ;
            end
            smsort_pkg::S_READ: begin
                n_state = smsort_pkg::S_CMP;
            end
            smsort_pkg::S_CMP: begin
                n_k = k_inc;
                if (take_a) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                if (k_inc == r_hi) begin
                    if (r_hi == r_n) begin
                        n_src = !r_src;
                        n_lo  = '0;
                        if (w2 >= {2'b00, r_n}) begin
                            n_k     = '0;
                            n_state = smsort_pkg::S_EREAD;
                        end else begin
                            n_w     = w2[CW:0];
                            n_state = smsort_pkg::S_RUN;
                        end
                    end else begin
                        n_lo    = r_hi;
                        n_state = smsort_pkg::S_RUN;
                    end
                end else begin
                    n_state = smsort_pkg::S_READ;
                end
            end
            smsort_pkg::S_EREAD: begin
                n_state = smsort_pkg::S_EOUT;
            end
            smsort_pkg::S_EOUT: begin
                if (k_inc == r_n) begin
                    n_count   = '0;
                    n_dropped = 1'b0;
                    n_state   = smsort_pkg::S_LOAD;
                end else begin
                    n_k     = k_inc;
                    n_state = smsort_pkg::S_EREAD;
                end
            end
            default: begin
                n_state = smsort_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= smsort_pkg::S_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_src <= n_src;
    end

    assign o_strobe    = (r_state == smsort_pkg::S_EOUT);
    assign o_value_res = $signed(rd_a);
    assign o_last_res  = o_strobe && (k_inc == r_n);
    assign o_overflow  = o_strobe && r_dropped;

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> busy)
        else $error("list end did not start sorting");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_k < r_n))
        else $error("emit index beyond list length");

    a_merge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smsort_pkg::S_CMP) |-> ((r_k < r_hi) && (cmp_ctl.a_ok || cmp_ctl.b_ok)))
        else $error("merge step with no element left in run");

    a_merge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smsort_pkg::S_CMP) |-> ((r_i - r_lo) + (r_j - r_mid) == (r_k - r_lo)))
        else $error("merge indices out of step");

endmodule
